### rtl/core/ffc_pkg.sv
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared opcodes, widths and constants for the float format converter.
// ----------------------------------------------------------------------------
package ffc_pkg;

    localparam int OPCODE_W = 2;
    localparam int WORD_W   = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_F32_TO_F16  = 2'd0,
        OP_F16_TO_F32  = 2'd1,
        OP_F32_TO_BF16 = 2'd2,
        OP_BF16_TO_F32 = 2'd3
    } opcode_t;

    localparam logic [31:0] INF32       = 32'h7F80_0000;
    localparam logic [31:0] F16_OVF_MAG = 32'h4780_0000;
    localparam logic [31:0] F16_MIN_NRM = 32'h3880_0000;
    localparam logic [31:0] F16_ZERO_TH = 32'h3300_0000;
    localparam logic [31:0] EXP_REBIAS  = 32'h3800_0000;

endpackage

### rtl/core/ffc_convert.sv
// ----------------------------------------------------------------------------
// ffc_convert
// Combinational conversion of one item: fp32/fp16/bf16 bit patterns.
// ----------------------------------------------------------------------------
module ffc_convert (
    input  ffc_pkg::opcode_t   opcode,
    input  logic [31:0]        operand,
    output logic [31:0]        converted
);

    // fp32 -> fp16
    logic [15:0] h_res;
    logic        x_sign;
    logic [30:0] mag;
    logic [31:0] r_nrm;
    logic [31:0] r_sub;
    logic [23:0] mant;
    logic [4:0]  sub_sh;
    logic [31:0] sub_add;

    assign x_sign = operand[31];
    assign mag    = operand[30:0];
    assign mant   = {1'b1, operand[22:0]};
    // exponent 102..112 gives shift 14..24
    assign sub_sh  = 5'(8'd126 - operand[30:23]);
    assign sub_add = {8'd0, mant} + (32'd1 << (sub_sh - 5'd1));
    assign r_sub   = sub_add >> sub_sh;
    assign r_nrm   = {1'b0, mag} + 32'h0FFF + {31'd0, mag[13]} - ffc_pkg::EXP_REBIAS;

    always_comb begin
        if ({1'b0, mag} > ffc_pkg::INF32) begin
            h_res = {x_sign, 15'h7E00};
        end else if ({1'b0, mag} >= ffc_pkg::F16_OVF_MAG) begin
            h_res = {x_sign, 15'h7C00};
        end else if ({1'b0, mag} >= ffc_pkg::F16_MIN_NRM) begin
            h_res = {x_sign, r_nrm[27:13]};
        end else if ({1'b0, mag} <= ffc_pkg::F16_ZERO_TH) begin
            h_res = {x_sign, 15'd0};
        end else begin
            h_res = {x_sign, r_sub[14:0]};
        end
    end

    // fp16 -> fp32, subnormals normalized through a leading-zero count
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [3:0]  lz;
    logic [9:0]  hm_norm;
    logic [31:0] f_res;

    assign he = operand[14:10];
    assign hm = operand[9:0];

    // highest set bit wins, as it is the last one visited
    always_comb begin
        lz = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (hm[i]) begin
                lz = 4'(9 - i);
            end
        end
    end

    // shift past the leading one so it drops out
    assign hm_norm = hm << (lz + 4'd1);

    always_comb begin
        if (he == 5'h1F) begin
            f_res = {operand[15], 8'hFF, hm, 13'd0};
        end else if (he != 5'd0) begin
            f_res = {operand[15], 8'(he) + 8'd112, hm, 13'd0};
        end else if (hm == 10'd0) begin
            f_res = {operand[15], 31'd0};
        end else begin
            f_res = {operand[15], 8'd112 - 8'(lz), hm_norm, 13'd0};
        end
    end

    // fp32 -> bf16
    logic [31:0] b_sum;
    logic [15:0] b_res;

    assign b_sum = operand + 32'h7FFF + {31'd0, operand[16]};
    assign b_res = ({1'b0, mag} > ffc_pkg::INF32) ? operand[31:16] | 16'h0040
                                                   : b_sum[31:16];

    // result select
    always_comb begin
        unique case (opcode)
            ffc_pkg::OP_F32_TO_F16:  converted = {16'd0, h_res};
            ffc_pkg::OP_F16_TO_F32:  converted = f_res;
            ffc_pkg::OP_F32_TO_BF16: converted = {16'd0, b_res};
            ffc_pkg::OP_BF16_TO_F32: converted = {operand[15:0], 16'd0};
            default:                 converted = '0;
        endcase
    end

endmodule

### rtl/core/float_format_converter_top.sv
// ----------------------------------------------------------------------------
// float_format_converter_top
// Converts raw float bit words between fp32, fp16 and bfloat16.
// ----------------------------------------------------------------------------
//  channel | ports                        | direction
//  input   | s_valid s_ready s_opcode s_operand | in
//  result  | m_valid m_ready m_converted  | out
//
//  One item per cycle; s_ready is high whenever the result register is
//  empty or being taken, so a stall on m_ready stalls the input. An item's
//  result appears in the cycle after it is taken. The conversion logic sits
//  between the input handshake and one result register. Reset clears m_valid.
// ----------------------------------------------------------------------------
module float_format_converter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_operand,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_converted
);

    logic        valid_reg;
    logic [31:0] data_reg;
    logic [31:0] conv;

    ffc_convert u_convert (
        .opcode   (ffc_pkg::opcode_t'(s_opcode)),
        .operand  (s_operand),
        .converted(conv)
    );

    assign s_ready     = !valid_reg || m_ready;
    assign m_valid     = valid_reg;
    assign m_converted = data_reg;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= conv;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_converted))
        else $error("result changed while stalled");
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted item lost");
    a_bf16: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode == ffc_pkg::OP_BF16_TO_F32
        |=> m_converted[15:0] == 16'd0)
        else $error("bf16 widening low half not zero");

endmodule
